// ===== src/lpf_pkg.sv =====
// Package with the shared types and constants of the Laplacian RGB filter.
`default_nettype none

package lpf_pkg;

   localparam int MAX_WIDTH_DEFAULT = 2048;
   localparam int MAX_HEIGHT        = 4096;
   localparam int CHAN_W            = 16;
   localparam int SUM_W             = 19;
   localparam int OUT_COL_W         = 11;
   localparam int ROW_W             = 12;
   localparam int CFG_WIDTH_W       = 12;
   localparam int CFG_HEIGHT_W      = 13;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;
   localparam int FIFO_DEPTH        = 4;

   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_WIDTH  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_HEIGHT = 3'd4;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      logic                 produce;
      logic                 frame_last;
      logic [OUT_COL_W-1:0] column;
      logic [ROW_W-1:0]     row;
   } ctrl_type;

   typedef struct packed {
      logic [ROW_W-1:0]        row;
      logic [OUT_COL_W-1:0]    column;
      logic signed [SUM_W-1:0] blue;
      logic signed [SUM_W-1:0] green;
      logic signed [SUM_W-1:0] red;
   } result_type;

   typedef struct packed {
      logic s1_valid;
      logic s2_valid;
   } status_type;

endpackage

`default_nettype wire

// ===== src/laplacian_3x3_rgb_filter_core.sv =====
// Top level of the four-neighbour 3x3 Laplacian filter for RGB pixel streams.
// Pixels enter on the req_ channel in raster order, one transfer per pixel, with
// red, green and blue packed in req_tdata. For each interior pixel one result
// leaves on the rsp_ channel: three signed 19-bit sums, the centre column and
// row, and rsp_tlast on the last interior result of a frame. Border pixels
// yield no transfer. The result of the pixel at (row, col) leaves with the
// transfer of the pixel at (row+1, col+1), passing the two datapath stages
// and the output queue. One pixel is taken per clock while req_tready is high;
// the line store memory is read at acceptance, written back the cycle after.
// A four-entry output queue is guarded by credits: req_tready is high while the
// queued results and the pixels in the two datapath stages number fewer than
// four. When the receiver stalls, req_tready drops once that sum reaches four
// and rises again as the queue drains.
// The user writes image width and height through the csr_ port while idle;
// the block does not enforce it. Reset clears counters, window and queue and
// sets the size to 640 by 480; line store memory is not cleared, nor need be.
`default_nettype none

module laplacian_3x3_rgb_filter_core #(
   parameter int MAX_WIDTH = lpf_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // req_tdata: in_red, in_green, in_blue
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [47:0]                    req_tdata,
   // rsp_tdata: out_red, out_green, out_blue, out_column, out_row
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [79:0]                         rsp_tdata,
   output logic                                rsp_tlast,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [lpf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [lpf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lpf_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int IDX_W  = $clog2(MAX_WIDTH);
   localparam int WCMP_W = IDX_W + lpf_pkg::CFG_WIDTH_W;
   localparam int COLX_W = IDX_W + lpf_pkg::OUT_COL_W;
   localparam int HW     = lpf_pkg::CFG_HEIGHT_W;
   localparam int PTR_W  = $clog2(lpf_pkg::FIFO_DEPTH);
   localparam int CNT_W  = $clog2(lpf_pkg::FIFO_DEPTH + 1);

   logic [lpf_pkg::CFG_WIDTH_W-1:0] width_ff;
   logic [HW-1:0]                   height_ff;
   logic                            csr_write;

   logic [IDX_W-1:0]          col_ff, col_in;
   logic [lpf_pkg::ROW_W-1:0] row_ff, row_in;

   logic                accept;
   logic [WCMP_W-1:0]   width_x, w_eff, col_x;
   logic [HW-1:0]       h_eff;
   logic [COLX_W-1:0]   col_m1;
   logic                row_end;
   lpf_pkg::ctrl_type   ctrl;

   lpf_pkg::status_type status;
   lpf_pkg::ctrl_type   out_ctrl;
   lpf_pkg::result_type result;

   lpf_pkg::result_type fifo_data_ff [lpf_pkg::FIFO_DEPTH];
   logic                fifo_last_ff [lpf_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W:0]      reserved;
   logic                push, pop;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lpf_pkg::WIDTH_RESET;
         height_ff <= lpf_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         if (csr_paddr == lpf_pkg::CSR_ADDR_WIDTH) begin
            width_ff <= csr_pwdata[lpf_pkg::CFG_WIDTH_W-1:0];
         end else if (csr_paddr == lpf_pkg::CSR_ADDR_HEIGHT) begin
            height_ff <= csr_pwdata[HW-1:0];
         end
      end
   end

   always_comb begin
      case (csr_paddr)
         lpf_pkg::CSR_ADDR_WIDTH:  csr_prdata = {20'd0, width_ff};
         lpf_pkg::CSR_ADDR_HEIGHT: csr_prdata = {19'd0, height_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   // Raster position and effective image size.
   assign accept  = req_tvalid && req_tready;
   assign width_x = {{IDX_W{1'b0}}, width_ff};
   assign col_x   = {{lpf_pkg::CFG_WIDTH_W{1'b0}}, col_ff};

   always_comb begin
      if (width_x < WCMP_W'(3)) begin
         w_eff = WCMP_W'(3);
      end else if (width_x > WCMP_W'(MAX_WIDTH)) begin
         w_eff = WCMP_W'(MAX_WIDTH);
      end else begin
         w_eff = width_x;
      end
      if (height_ff < HW'(3)) begin
         h_eff = HW'(3);
      end else if (height_ff > HW'(lpf_pkg::MAX_HEIGHT)) begin
         h_eff = HW'(lpf_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   assign row_end = col_x >= (w_eff - WCMP_W'(1));
   assign col_m1  = {{lpf_pkg::OUT_COL_W{1'b0}}, col_ff} - COLX_W'(1);

   assign ctrl.produce    = (row_ff >= lpf_pkg::ROW_W'(2)) && (col_ff >= IDX_W'(2));
   assign ctrl.frame_last = row_end && ({1'b0, row_ff} >= (h_eff - HW'(1)));
   assign ctrl.column     = col_m1[lpf_pkg::OUT_COL_W-1:0];
   assign ctrl.row        = row_ff - lpf_pkg::ROW_W'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = ctrl.frame_last ? '0 : row_ff + lpf_pkg::ROW_W'(1);
         end else begin
            col_in = col_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   lpf_datapath #(
      .MAX_WIDTH (MAX_WIDTH),
      .IDX_W     (IDX_W)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .idx      (col_ff),
      .pixel    (lpf_pkg::pixel_type'(req_tdata)),
      .ctrl     (ctrl),
      .status   (status),
      .out_ctrl (out_ctrl),
      .result   (result)
   );

   // Output queue with credit for the items still in the datapath.
   assign reserved   = {1'b0, cnt_ff} + (CNT_W + 1)'(status.s1_valid)
                       + (CNT_W + 1)'(status.s2_valid);
   assign req_tready = reserved < (CNT_W + 1)'(lpf_pkg::FIFO_DEPTH);

   assign push = status.s2_valid && out_ctrl.produce;
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_data_ff[wr_ptr_ff] <= result;
         fifo_last_ff[wr_ptr_ff] <= out_ctrl.frame_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   assign rsp_tvalid = cnt_ff != '0;
   assign rsp_tdata  = fifo_data_ff[rd_ptr_ff];
   assign rsp_tlast  = fifo_last_ff[rd_ptr_ff];

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      reserved <= (CNT_W + 1)'(lpf_pkg::FIFO_DEPTH))
      else $error("more items in flight than queue entries");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && cnt_ff == CNT_W'(lpf_pkg::FIFO_DEPTH)))
      else $error("result pushed into a full queue");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      accept |=> (col_ff == '0) || (col_ff == $past(col_ff) + IDX_W'(1)))
      else $error("column counter skipped");

   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      accept |=> status.s1_valid ##1 status.s2_valid)
      else $error("accepted pixel left the datapath early");

endmodule

`default_nettype wire

// ===== src/lpf_datapath.sv =====
// Line store memory, 3x3 pixel window and Laplacian sums of the filter.
`default_nettype none

module lpf_datapath #(
   parameter int MAX_WIDTH = lpf_pkg::MAX_WIDTH_DEFAULT,
   parameter int IDX_W     = $clog2(MAX_WIDTH)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [IDX_W-1:0]     idx,
   input  wire lpf_pkg::pixel_type   pixel,
   input  wire lpf_pkg::ctrl_type    ctrl,
   output lpf_pkg::status_type       status,
   output lpf_pkg::ctrl_type         out_ctrl,
   output lpf_pkg::result_type       result
);

   localparam int PIX_W = $bits(lpf_pkg::pixel_type);

   logic [2*PIX_W-1:0]  mem [MAX_WIDTH];
   logic [2*PIX_W-1:0]  rd_ff;

   logic                s1_valid_ff;
   logic [IDX_W-1:0]    s1_idx_ff;
   lpf_pkg::pixel_type  s1_px_ff;
   lpf_pkg::ctrl_type   s1_ctrl_ff;

   logic                s2_valid_ff;
   lpf_pkg::ctrl_type   s2_ctrl_ff;
   lpf_pkg::pixel_type  win_ff [3][3];

   lpf_pkg::pixel_type  rd_upper;
   lpf_pkg::pixel_type  rd_middle;

   function automatic logic signed [lpf_pkg::SUM_W-1:0] lap(
      input logic [lpf_pkg::CHAN_W-1:0] up,
      input logic [lpf_pkg::CHAN_W-1:0] dn,
      input logic [lpf_pkg::CHAN_W-1:0] lf,
      input logic [lpf_pkg::CHAN_W-1:0] rt,
      input logic [lpf_pkg::CHAN_W-1:0] ce
   );
      logic [lpf_pkg::SUM_W-1:0] s;
      s = {3'b000, up} + {3'b000, dn} + {3'b000, lf} + {3'b000, rt}
          - {1'b0, ce, 2'b00};
      return s;
   endfunction

   assign rd_upper  = rd_ff[2*PIX_W-1:PIX_W];
   assign rd_middle = rd_ff[PIX_W-1:0];

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= mem[idx];
      end
      if (s1_valid_ff) begin
         mem[s1_idx_ff] <= {rd_middle, s1_px_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff  <= idx;
         s1_px_ff   <= pixel;
         s1_ctrl_ff <= ctrl;
      end
      if (s1_valid_ff) begin
         s2_ctrl_ff <= s1_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[r][0] <= win_ff[r][1];
               win_ff[r][1] <= win_ff[r][2];
            end
            win_ff[0][2] <= rd_upper;
            win_ff[1][2] <= rd_middle;
            win_ff[2][2] <= s1_px_ff;
         end
      end
   end

   assign status.s1_valid = s1_valid_ff;
   assign status.s2_valid = s2_valid_ff;
   assign out_ctrl        = s2_ctrl_ff;

   assign result.row    = s2_ctrl_ff.row;
   assign result.column = s2_ctrl_ff.column;
   assign result.red    = lap(win_ff[0][1].red, win_ff[2][1].red, win_ff[1][0].red,
                              win_ff[1][2].red, win_ff[1][1].red);
   assign result.green  = lap(win_ff[0][1].green, win_ff[2][1].green, win_ff[1][0].green,
                              win_ff[1][2].green, win_ff[1][1].green);
   assign result.blue   = lap(win_ff[0][1].blue, win_ff[2][1].blue, win_ff[1][0].blue,
                              win_ff[1][2].blue, win_ff[1][1].blue);

endmodule

`default_nettype wire
